FILE: rtl/core/clp_pkg.sv
// types, constants and codes shared by the calibrated line position block
`timescale 1ns / 1ps
package clp_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SIDX_W      = $clog2(NUM_SENSORS);
  localparam int RAW_W       = 12;
  localparam int NORM_W      = 10;
  localparam int POS_W       = 13;

  localparam logic [RAW_W-1:0]  MAX_COUNT  = 12'd4095;
  localparam logic [NORM_W-1:0] FULL_SCALE = 10'd1000;

  // sum of index * norm and sum of norms over all sensors
  localparam int WSUM_W = 15;
  localparam int DEN_W  = 13;

  // shared divider: dividend, divisor and quotient widths
  localparam int DIV_NW = WSUM_W + NORM_W;
  localparam int DIV_DW = 13;
  localparam int DIV_QW = 13;
  localparam int DIV_CW = $clog2(DIV_QW);

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_FINISH  = 2'd2,
    OP_MEASURE = 2'd3
  } clp_op_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_BLACK = 2'd1,
    ST_UNCAL = 2'd2,
    ST_CALACK = 2'd3
  } clp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCALE_MUL,
    S_SCALE_START,
    S_SCALE_WAIT,
    S_CENT_CHECK,
    S_CENT_MUL,
    S_CENT_START,
    S_CENT_WAIT,
    S_FINISH
  } clp_state_t;

  typedef struct packed {
    clp_op_t          cmd;
    logic [RAW_W-1:0] raw_0;
    logic [RAW_W-1:0] raw_1;
    logic [RAW_W-1:0] raw_2;
    logic [RAW_W-1:0] raw_3;
    logic [RAW_W-1:0] raw_4;
    logic [RAW_W-1:0] raw_5;
    logic [RAW_W-1:0] raw_6;
    logic [RAW_W-1:0] raw_7;
  } clp_in_t;

  typedef struct packed {
    clp_status_t       status;
    logic [POS_W-1:0]  position;
    logic [NORM_W-1:0] norm_0;
    logic [NORM_W-1:0] norm_1;
    logic [NORM_W-1:0] norm_2;
    logic [NORM_W-1:0] norm_3;
    logic [NORM_W-1:0] norm_4;
    logic [NORM_W-1:0] norm_5;
    logic [NORM_W-1:0] norm_6;
    logic [NORM_W-1:0] norm_7;
  } clp_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic scale_mul;
    logic div_start;
    logic div_centroid;
    logic store_norm;
    logic next_sensor;
    logic cent_mul;
    logic store_pos;
    logic load_out;
  } clp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_measure;
    logic calibrated;
    logic last_sensor;
    logic div_done;
    logic all_sat;
    logic any_sat;
  } clp_stat_t;

endpackage

FILE: rtl/core/clp_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module clp_div
  import clp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_QW-1:0] quot
);

  logic [DIV_NW-1:0] rem;
  logic [DIV_NW-1:0] dvs;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              fits;

  assign fits = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient is known to fit in DIV_QW bits, so the divisor starts shifted up by DIV_QW-1
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dvs  <= DIV_NW'({divisor, {(DIV_QW-1){1'b0}}});
      quot <= '0;
      cnt  <= DIV_CW'(DIV_QW - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dvs;
      end
      quot <= {quot[DIV_QW-2:0], fits};
      dvs  <= dvs >> 1;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

FILE: rtl/core/clp_dp.sv
// datapath: calibration minima, scaling, centroid sums and result register
`timescale 1ns / 1ps
module clp_dp
  import clp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RAW_W-1:0] cfg_wdata,
  input  clp_in_t          item,
  input  clp_cmd_t         cmd,
  output clp_stat_t        stat,
  output clp_out_t         result
);

  logic [RAW_W-1:0]  min_valid;
  logic [RAW_W-1:0]  min_rd [NUM_SENSORS];
  logic [RAW_W-1:0]  raw    [NUM_SENSORS];
  logic [NORM_W-1:0] norm   [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] sat;
  clp_op_t           op;
  logic              calibrated;
  logic [POS_W-1:0]  last_pos;
  logic [SIDX_W-1:0] k;

  logic [DIV_NW-1:0] prod;
  logic [RAW_W-1:0]  span;
  logic              zero;
  logic [WSUM_W-1:0] wsum;
  logic [DEN_W-1:0]  den;
  logic [DIV_NW-1:0] num;

  logic [RAW_W-1:0]        diff;
  logic [RAW_W+NORM_W-1:0] mul_scale;
  logic [DIV_NW-1:0]       mul_cent;
  logic [NORM_W-1:0]       nv;
  logic [WSUM_W-1:0]       wterm;
  logic [DIV_NW-1:0]       div_n;
  logic [DIV_DW-1:0]       div_d;
  logic                    div_done;
  logic [DIV_QW-1:0]       quot;
  clp_status_t             status;

  assign diff      = raw[k] - min_rd[k];
  assign mul_scale = {{NORM_W{1'b0}}, diff} * {{RAW_W{1'b0}}, FULL_SCALE};
  assign mul_cent  = {{NORM_W{1'b0}}, wsum} * {{WSUM_W{1'b0}}, FULL_SCALE};

  // zero span or reading at or below the minimum gives 0, overshoot clamps to full scale
  always_comb begin
    if (zero) begin
      nv = '0;
    end else if (quot > DIV_QW'(FULL_SCALE)) begin
      nv = FULL_SCALE;
    end else begin
      nv = quot[NORM_W-1:0];
    end
  end

  assign wterm = WSUM_W'(k) * WSUM_W'(nv);

  assign div_n = cmd.div_centroid ? num : prod;
  assign div_d = cmd.div_centroid ? DIV_DW'(den) : DIV_DW'(span);

  clp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid  <= '0;
      calibrated <= 1'b0;
      last_pos   <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        min_rd[i] <= MAX_COUNT;
      end
    end else begin
      if (cfg_we) begin
        min_valid <= cfg_wdata;
      end
      if (cmd.decode) begin
        unique case (op)
          OP_BEGIN: begin
            calibrated <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
              min_rd[i] <= MAX_COUNT;
            end
          end
          OP_SAMPLE: begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
              if ((raw[i] < min_rd[i]) && (raw[i] > min_valid)) begin
                min_rd[i] <= raw[i];
              end
            end
          end
          OP_FINISH: begin
            calibrated <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.store_pos && (den != '0)) begin
        last_pos <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= item.cmd;
      raw[0] <= item.raw_0;
      raw[1] <= item.raw_1;
      raw[2] <= item.raw_2;
      raw[3] <= item.raw_3;
      raw[4] <= item.raw_4;
      raw[5] <= item.raw_5;
      raw[6] <= item.raw_6;
      raw[7] <= item.raw_7;
    end
    if (cmd.decode) begin
      k    <= '0;
      wsum <= '0;
      den  <= '0;
      sat  <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        norm[i] <= '0;
      end
    end
    if (cmd.scale_mul) begin
      prod <= DIV_NW'(mul_scale);
      span <= MAX_COUNT - min_rd[k];
      zero <= (min_rd[k] >= MAX_COUNT) || (raw[k] <= min_rd[k]);
    end
    if (cmd.store_norm) begin
      norm[k] <= nv;
      sat[k]  <= (nv == FULL_SCALE);
      wsum    <= wsum + wterm;
      den     <= den + DEN_W'(nv);
    end
    if (cmd.next_sensor) begin
      k <= k + 1'b1;
    end
    if (cmd.cent_mul) begin
      num <= mul_cent;
    end
  end

  always_comb begin
    if (op != OP_MEASURE) begin
      status = ST_CALACK;
    end else if (!calibrated) begin
      status = ST_UNCAL;
    end else if (&sat) begin
      status = ST_BLACK;
    end else begin
      status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.status   <= status;
      result.position <= last_pos;
      result.norm_0   <= norm[0];
      result.norm_1   <= norm[1];
      result.norm_2   <= norm[2];
      result.norm_3   <= norm[3];
      result.norm_4   <= norm[4];
      result.norm_5   <= norm[5];
      result.norm_6   <= norm[6];
      result.norm_7   <= norm[7];
    end
  end

  assign stat.is_measure  = (op == OP_MEASURE);
  assign stat.calibrated  = calibrated;
  assign stat.last_sensor = (k == SIDX_W'(NUM_SENSORS - 1));
  assign stat.div_done    = div_done;
  assign stat.all_sat     = &sat;
  assign stat.any_sat     = |sat;

endmodule

FILE: rtl/core/clp_ctrl.sv
// controller: sequences one item through decode and, for a calibrated measure, scaling and optional centroid division
`timescale 1ns / 1ps
module clp_ctrl
  import clp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  output logic      result_valid,
  input  logic      result_ready,
  input  clp_stat_t stat,
  output clp_cmd_t  cmd
);

  clp_state_t state, state_next;
  logic       out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_measure && stat.calibrated) begin
          state_next = S_SCALE_MUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCALE_MUL:   state_next = S_SCALE_START;
      S_SCALE_START: state_next = S_SCALE_WAIT;
      S_SCALE_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.last_sensor ? S_CENT_CHECK : S_SCALE_MUL;
        end
      end
      S_CENT_CHECK: begin
        // a centroid only when some but not all sensors saturate
        if (stat.any_sat && !stat.all_sat) begin
          state_next = S_CENT_MUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CENT_MUL:   state_next = S_CENT_START;
      S_CENT_START: state_next = S_CENT_WAIT;
      S_CENT_WAIT: begin
        if (stat.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready  = 1'b1;
        cmd.capture = item_valid;
      end
      S_DECODE:      cmd.decode = 1'b1;
      S_SCALE_MUL:   cmd.scale_mul = 1'b1;
      S_SCALE_START: cmd.div_start = 1'b1;
      S_SCALE_WAIT: begin
        cmd.store_norm  = stat.div_done;
        cmd.next_sensor = stat.div_done && !stat.last_sensor;
      end
      S_CENT_CHECK: begin
      end
      S_CENT_MUL:   cmd.cent_mul = 1'b1;
      S_CENT_START: begin
        cmd.div_start    = 1'b1;
        cmd.div_centroid = 1'b1;
      end
      S_CENT_WAIT: cmd.store_pos = stat.div_done;
      S_FINISH:    cmd.load_out = out_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/calibrated_line_position_top.sv
// top level: calibrated reflectance line position with handshake channels
// calibration commands and uncalibrated measures: decode, then finish loads the result register
// calibrated measure: each sensor in turn on one shared serial divider (multiply, start,
// 13 steps, store), then a centroid division on the same divider when one is needed
// one item at a time; the next transfer may come while the result waits in its register
// sync reset: minima go to full count, calibrated mark, held position and threshold clear
`timescale 1ns / 1ps
module calibrated_line_position_top
  import clp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [RAW_W-1:0] cfg_wdata,
  input  logic             item_valid,
  output logic             item_ready,
  input  clp_in_t          item,
  output logic             result_valid,
  input  logic             result_ready,
  output clp_out_t         result
);

  clp_cmd_t  cmd;
  clp_stat_t stat;

  clp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  clp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule
